### rtl/core/byte_stuffed_frame_decoder_macros.svh
// Assertion macros shared by the frame decoder RTL.
// Expects i_clk and i_rst_n in the scope of the module that uses them.
`ifndef BYTE_STUFFED_FRAME_DECODER_MACROS_SVH
`define BYTE_STUFFED_FRAME_DECODER_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define BSFD_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define BSFD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/bsfd_pkg.sv
// Shared constants and types for the byte-stuffed frame decoder.
// No dependencies.
`timescale 1ns / 1ps

package bsfd_pkg;

    localparam logic [7:0]  START_BYTE      = 8'hFF;
    localparam logic [7:0]  ESC_BYTE        = 8'hFD;
    localparam logic [7:0]  ESC_FF_CODE     = 8'hFE;
    localparam logic [15:0] HEADER_BYTES    = 16'd3;
    localparam logic [15:0] MAX_PAYLOAD_RST = 16'hFFFF;

    // Registered input beat handed from the input stage to the decoder.
    typedef struct packed {
        logic       valid;
        logic [7:0] rx_byte;
    } t_in_beat;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        data_valid;
        logic        frame_end;
        logic [15:0] delivered_count;
    } t_result;

endpackage

### rtl/core/bsfd_ifs.sv
// Valid/ready channel interfaces for received bytes and decoded results.
// Depends on nothing.
`timescale 1ns / 1ps

interface bsfd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface bsfd_result_if;
    logic        valid;
    logic        ready;
    logic [7:0]  data_byte;
    logic        data_valid;
    logic        frame_end;
    logic [15:0] delivered_count;

    modport source (output valid, output data_byte, output data_valid,
                    output frame_end, output delivered_count, input ready);
    modport sink   (input valid, input data_byte, input data_valid,
                    input frame_end, input delivered_count, output ready);
endinterface

### rtl/core/byte_stuffed_frame_decoder.sv
// Path: an accepted byte passes the input register, then the result register.
// Throughput: one byte per cycle while o_res is ready; both registers refill
//   in the cycle they drain, so a stalled result holds at most one byte.
// Reset: synchronous, active low; returns to hunting for the start byte,
//   max_payload back to 65535, no result pending.
`timescale 1ns / 1ps

module byte_stuffed_frame_decoder
    import bsfd_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  logic [15:0]    i_cfg_wdata,
    bsfd_byte_if.sink      i_rx,
    bsfd_result_if.source  o_res
);

    t_in_beat beat;
    logic     take;

    bsfd_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (i_rx),
        .i_take  (take),
        .o_beat  (beat)
    );

    bsfd_decoder u_decoder (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_beat      (beat),
        .o_take      (take),
        .o_res       (o_res)
    );

endmodule

### rtl/core/bsfd_in_stage.sv
// Input register for received bytes.
// Depends on bsfd_pkg and bsfd_byte_if.
`timescale 1ns / 1ps

module bsfd_in_stage
    import bsfd_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    bsfd_byte_if.sink      i_rx,
    input  logic           i_take,
    output t_in_beat       o_beat
);

    logic       r_valid;
    logic [7:0] r_rx_byte;

    // Refill in the same cycle the held beat is consumed.
    assign i_rx.ready = !r_valid || i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_rx.ready) begin
            r_valid <= i_rx.valid;
        end
        if (i_rx.valid && i_rx.ready) begin
            r_rx_byte <= i_rx.rx_byte;
        end
    end

    assign o_beat.valid   = r_valid;
    assign o_beat.rx_byte = r_rx_byte;

endmodule

### rtl/core/bsfd_decoder.sv
// Frame state machine, unstuffing logic and result register.
// Depends on bsfd_pkg, bsfd_result_if and the assertion macro header.
`timescale 1ns / 1ps

module bsfd_decoder
    import bsfd_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  logic [15:0]    i_cfg_wdata,
    input  t_in_beat       i_beat,
    output logic           o_take,
    bsfd_result_if.source  o_res
);

`include "byte_stuffed_frame_decoder_macros.svh"

    typedef enum logic [1:0] {PH_HUNT, PH_LEN_HI, PH_LEN_LO, PH_BODY} t_phase;

    t_phase      r_phase, n_phase;
    logic [7:0]  r_len_high, n_len_high;
    logic [15:0] r_remaining, n_remaining;
    logic        r_esc, n_esc;
    logic [15:0] r_delivered, n_delivered;
    logic [15:0] r_max_payload;
    logic        r_out_valid;
    t_result     r_out, n_out;
    logic        n_emit;

    logic [7:0]  b;
    logic [15:0] total;
    logic        have;
    logic [7:0]  dec;
    logic        deliver;
    logic        last;
    logic [15:0] rem_dec;

    assign b      = i_beat.rx_byte;
    assign total  = {r_len_high, b};
    assign o_take = i_beat.valid && (!r_out_valid || o_res.ready);

    always_comb begin
        n_phase     = r_phase;
        n_len_high  = r_len_high;
        n_remaining = r_remaining;
        n_esc       = r_esc;
        n_delivered = r_delivered;
        n_emit      = 1'b0;
        n_out       = '0;
        have        = 1'b0;
        dec         = '0;
        deliver     = 1'b0;
        last        = 1'b0;
        rem_dec     = (r_remaining != 16'd0) ? r_remaining - 16'd1 : 16'd0;

        unique case (r_phase)
            PH_HUNT: begin
                if (b == START_BYTE) begin
                    n_phase = PH_LEN_HI;
                end
            end
            PH_LEN_HI: begin
                n_len_high = b;
                n_phase    = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                n_delivered = '0;
                n_esc       = 1'b0;
                if (total <= HEADER_BYTES) begin
                    // short length: empty frame closes right here
                    n_remaining     = '0;
                    n_phase         = PH_HUNT;
                    n_emit          = 1'b1;
                    n_out.frame_end = 1'b1;
                end else begin
                    n_remaining = total - HEADER_BYTES;
                    n_phase     = PH_BODY;
                end
            end
            PH_BODY: begin
                if (r_esc) begin
                    n_esc = 1'b0;
                    if (b == ESC_FF_CODE) begin
                        have = 1'b1;
                        dec  = START_BYTE;
                    end else if (b == ESC_BYTE) begin
                        have = 1'b1;
                        dec  = ESC_BYTE;
                    end
                end else if (b == ESC_BYTE) begin
                    n_esc = 1'b1;
                end else begin
                    have = 1'b1;
                    dec  = b;
                end
                deliver = have && (r_delivered < r_max_payload);
                if (deliver) begin
                    n_delivered = r_delivered + 16'd1;
                end
                n_remaining = rem_dec;
                last        = (rem_dec == 16'd0);
                if (last) begin
                    // a dangling escape dies with the frame
                    n_esc   = 1'b0;
                    n_phase = PH_HUNT;
                end
                n_emit                = deliver || last;
                n_out.data_byte       = deliver ? dec : 8'h00;
                n_out.data_valid      = deliver;
                n_out.frame_end       = last;
                n_out.delivered_count = n_delivered;
            end
            default: begin
                n_phase = PH_HUNT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_HUNT;
            r_len_high    <= '0;
            r_remaining   <= '0;
            r_esc         <= 1'b0;
            r_delivered   <= '0;
            r_max_payload <= MAX_PAYLOAD_RST;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_max_payload <= i_cfg_wdata;
            end
            if (o_take) begin
                r_phase     <= n_phase;
                r_len_high  <= n_len_high;
                r_remaining <= n_remaining;
                r_esc       <= n_esc;
                r_delivered <= n_delivered;
            end
            if (o_take) begin
                r_out_valid <= n_emit;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (o_take && n_emit) begin
            r_out <= n_out;
        end
    end

    assign o_res.valid           = r_out_valid;
    assign o_res.data_byte       = r_out.data_byte;
    assign o_res.data_valid      = r_out.data_valid;
    assign o_res.frame_end       = r_out.frame_end;
    assign o_res.delivered_count = r_out.delivered_count;

    `BSFD_ASSERT_SAME(a_valid_has_count, r_out_valid && r_out.data_valid,
        r_out.delivered_count != 16'd0, "delivered byte with zero count")
    `BSFD_ASSERT_SAME(a_idle_byte_zero, r_out_valid && !r_out.data_valid,
        r_out.data_byte == 8'h00, "undelivered result carries nonzero byte")
    `BSFD_ASSERT_NEXT(a_end_to_hunt, o_take && n_emit && n_out.frame_end,
        r_phase == PH_HUNT && !r_esc, "frame end did not return to hunt")
    `BSFD_ASSERT_SAME(a_body_has_work, r_phase == PH_BODY,
        r_remaining != 16'd0, "body phase with nothing remaining")

endmodule
